// ===== rtl/sus_pkg.sv =====
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and codes for the sorted unique set block.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned InValW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // tdata layouts, zero filled to whole bytes
  localparam int unsigned InDataW  = ((InValW + PosW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((InValW + CountW + 7) / 8) * 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_DUP   = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_WRITE_NEW,
    ST_SHIFT_DN,
    ST_READ_WAIT,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/sorted_unique_set_top.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_set_top
// Sorted table of unique signed values held in one synchronous memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the operation (insert,
// erase at position, read at position), tdata the value and the position.
// Each request gives one transaction on m_axis: tuser carries the status,
// tdata the read value and the entry count after the request.
// The entries sit in a single-port-write, single-read memory with a registered
// read; a sequencer walks it one entry per cycle, so one request is handled at
// a time and s_axis_tready_o is high only while idle. A read fetches the entry
// at the position; an erase moves every later entry one place down; an insert
// scans the entries up to the insertion point, then moves the entries from
// there up by one place and writes the new value into the freed slot.
// The result sits in an output register, so the next request is taken while
// it waits; a request only stalls in its final step if the receiver still
// holds the previous result. Reset empties the set and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_top #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // s_axis_tdata_i: value [31:0], position [35:32], zero fill
  input  wire logic [sus_pkg::InDataW-1:0]  s_axis_tdata_i,
  // s_axis_tuser_i: func [1:0]
  input  wire logic [sus_pkg::FuncW-1:0]    s_axis_tuser_i,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // m_axis_tdata_o: read_value [31:0], entry_count [36:32], zero fill
  output logic [sus_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // m_axis_tuser_o: status [1:0]
  output logic [sus_pkg::StatusW-1:0]       m_axis_tuser_o,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > sus_pkg::PosW) ? CNT_W : sus_pkg::PosW;

  // memory
  logic [VALUE_WIDTH-1:0] mem_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  // control and request state
  sus_pkg::state_e        state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  sus_pkg::status_e       status_q, status_d;
  logic [31:0]            read_q, read_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  sus_pkg::status_e       out_status_q, out_status_d;
  logic [31:0]            out_read_q, out_read_d;
  logic [CNT_W-1:0]       out_count_q, out_count_d;

  // unpacked input fields
  logic [sus_pkg::InValW-1:0] in_value;
  logic [sus_pkg::PosW-1:0]   in_pos;
  sus_pkg::func_e             in_func;
  logic signed [63:0]         in_val_ext;
  logic signed [63:0]         rd_ext;
  logic                       full;
  logic                       pos_out_of_range;

  assign in_value   = s_axis_tdata_i[sus_pkg::InValW-1:0];
  assign in_pos     = s_axis_tdata_i[sus_pkg::InValW +: sus_pkg::PosW];
  assign in_func    = sus_pkg::func_e'(s_axis_tuser_i);
  assign in_val_ext = 64'(signed'(in_value));
  assign rd_ext     = 64'(signed'(rdata_q));
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign pos_out_of_range = (CMP_W'(in_pos) >= CMP_W'(count_q));

  assign s_axis_tready_o = (state_q == sus_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = sus_pkg::OutDataW'({sus_pkg::CountW'(out_count_q), out_read_q});

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sus_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    val_q        <= val_d;
    status_q     <= status_d;
    read_q       <= read_d;
    out_status_q <= out_status_d;
    out_read_q   <= out_read_d;
    out_count_q  <= out_count_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    val_d        = val_q;
    status_d     = status_q;
    read_d       = read_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_status_d = out_status_q;
    out_read_d   = out_read_q;
    out_count_d  = out_count_q;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rdata_q;

    case (state_q)
      sus_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          val_d    = in_val_ext[VALUE_WIDTH-1:0];
          status_d = sus_pkg::STATUS_DONE;
          read_d   = '0;
          state_d  = sus_pkg::ST_RESP;
          case (in_func)
            sus_pkg::FUNC_INSERT: begin
              if (count_q == '0) begin
                slot_d  = '0;
                state_d = sus_pkg::ST_WRITE_NEW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = '0;
                state_d   = sus_pkg::ST_SCAN;
              end
            end
            sus_pkg::FUNC_ERASE: begin
              if (pos_out_of_range) begin
                status_d = sus_pkg::STATUS_RANGE;
              end else if (CMP_W'(in_pos) == CMP_W'(count_q - 1'b1)) begin
                // last entry, nothing to move
                count_d = count_q - 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_pos) + 1'b1;
                idx_d     = AW'(in_pos) + 1'b1;
                state_d   = sus_pkg::ST_SHIFT_DN;
              end
            end
            sus_pkg::FUNC_READ: begin
              if (pos_out_of_range) begin
                status_d = sus_pkg::STATUS_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_pos);
                state_d   = sus_pkg::ST_READ_WAIT;
              end
            end
            default: begin
              state_d = sus_pkg::ST_RESP;
            end
          endcase
        end
      end

      // rdata_q holds entry idx_q; stop at the first entry not below the value
      sus_pkg::ST_SCAN: begin
        if (rdata_q == val_q) begin
          status_d = sus_pkg::STATUS_DUP;
          state_d  = sus_pkg::ST_RESP;
        end else if ($signed(val_q) < $signed(rdata_q)) begin
          if (full) begin
            status_d = sus_pkg::STATUS_FULL;
            state_d  = sus_pkg::ST_RESP;
          end else begin
            slot_d    = idx_q;
            mem_re    = 1'b1;
            mem_raddr = AW'(count_q - 1'b1);
            idx_d     = AW'(count_q - 1'b1);
            state_d   = sus_pkg::ST_SHIFT_UP;
          end
        end else if (CNT_W'(idx_q) + 1'b1 == count_q) begin
          if (full) begin
            status_d = sus_pkg::STATUS_FULL;
            state_d  = sus_pkg::ST_RESP;
          end else begin
            slot_d  = AW'(count_q);
            state_d = sus_pkg::ST_WRITE_NEW;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end

      // move entry idx_q one place up, walking down to the slot
      sus_pkg::ST_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q + 1'b1;
        mem_wdata = rdata_q;
        if (idx_q == slot_q) begin
          state_d = sus_pkg::ST_WRITE_NEW;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - 1'b1;
          idx_d     = idx_q - 1'b1;
        end
      end

      sus_pkg::ST_WRITE_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        mem_wdata = val_q;
        count_d   = count_q + 1'b1;
        state_d   = sus_pkg::ST_RESP;
      end

      // move entry idx_q one place down, walking up to the last entry
      sus_pkg::ST_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q - 1'b1;
        mem_wdata = rdata_q;
        if (CNT_W'(idx_q) + 1'b1 == count_q) begin
          count_d = count_q - 1'b1;
          state_d = sus_pkg::ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end

      sus_pkg::ST_READ_WAIT: begin
        read_d  = rd_ext[31:0];
        state_d = sus_pkg::ST_RESP;
      end

      sus_pkg::ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_read_d   = read_q;
          out_count_d  = count_q;
          state_d      = sus_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sus_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/sorted_unique_set_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_set_top_test
// Self-checking bench for the sorted unique set block.
// ----------------------------------------------------------------------------
// Requests go in from a queue through a driver with random gaps. A local copy
// of the sorted table predicts each result when its request is accepted. A
// monitor with random back-pressure compares every result transaction with
// the oldest prediction. Directed requests cover the empty set, extreme values,
// duplicates, out-of-range positions and the unused code. Random blocks then
// lean toward filling, draining or mixing the set, so full-set inserts and
// long shifts come up often.
// ----------------------------------------------------------------------------

module sorted_unique_set_top_test;
  import sus_pkg::*;

  localparam int Capacity      = 16;
  localparam int PadInW        = InDataW - InValW - PosW;
  localparam int WatchdogLimit = 4000;

  typedef struct packed {
    func_e             func;
    logic signed [31:0] value;
    logic [3:0]        position;
  } request_t;

  typedef struct packed {
    status_e           status;
    logic signed [31:0] read_value;
    logic [4:0]        entry_count;
  } result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [FuncW-1:0]    s_axis_tuser_i  = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StatusW-1:0]  m_axis_tuser_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;

  // shadow of the sorted table
  logic signed [31:0] sorted_vals [Capacity];
  int unsigned        sorted_cnt = 0;

  request_t pending_requests [$];
  result_t  pending_results [$];
  request_t cur_req;

  int  mismatches = 0;
  int  send_gap   = 0;
  int  recv_stall = 0;
  int  idle_cycles = 0;
  int  cycle_cnt  = 0;
  logic quiet_q   = 1'b0;

  sorted_unique_set_top #(
    .CAPACITY   (Capacity),
    .VALUE_WIDTH(32)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always #5 clk_i = ~clk_i;

  // applies one request to the shadow table and returns the result it gives
  function automatic result_t update_sorted_set(request_t rq);
    result_t res;
    int unsigned slot;
    res.status      = STATUS_DONE;
    res.read_value  = '0;
    case (rq.func)
      FUNC_INSERT: begin
        for (int i = 0; i < sorted_cnt; i++) begin
          if (sorted_vals[i] == rq.value) res.status = STATUS_DUP;
        end
        if (res.status == STATUS_DONE && sorted_cnt >= Capacity) res.status = STATUS_FULL;
        if (res.status == STATUS_DONE) begin
          slot = sorted_cnt;
          for (int i = sorted_cnt - 1; i >= 0; i--) begin
            if (rq.value < sorted_vals[i]) slot = i;
          end
          for (int i = sorted_cnt; i > slot; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[slot] = rq.value;
          sorted_cnt++;
        end
      end
      FUNC_ERASE: begin
        if (rq.position >= sorted_cnt) begin
          res.status = STATUS_RANGE;
        end else begin
          for (int i = rq.position; i + 1 < sorted_cnt; i++) sorted_vals[i] = sorted_vals[i+1];
          sorted_cnt--;
        end
      end
      FUNC_READ: begin
        if (rq.position >= sorted_cnt) res.status = STATUS_RANGE;
        else res.read_value = sorted_vals[rq.position];
      end
      default: ;
    endcase
    res.entry_count = sorted_cnt[4:0];
    return res;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_q || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // small values collide often, edges probe the signed compare
  function automatic logic [31:0] random_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 32'($urandom_range(15)) - 32'd8;
      5, 6, 9:       return $urandom();
      7:             return 32'h7fff_ffff - 32'($urandom_range(3));
      default:       return 32'h8000_0000 + 32'($urandom_range(3));
    endcase
  endfunction

  task automatic queue_request(func_e f, logic [31:0] v, logic [3:0] p);
    request_t rq;
    rq.func     = f;
    rq.value    = v;
    rq.position = p;
    pending_requests = {pending_requests, rq};
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid_i || pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt % 200 == 0) quiet_q <= ($urandom_range(3) == 0);
  end

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_results = {pending_results, update_sorted_set(cur_req)};
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0 || pending_requests.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          cur_req = pending_requests.pop_front();
          s_axis_tdata_i  <= {{PadInW{1'b0}}, cur_req.position, cur_req.value};
          s_axis_tuser_i  <= cur_req.func;
          s_axis_tvalid_i <= 1'b1;
          send_gap = pick_gap();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status      = status_e'(m_axis_tuser_o);
        got.read_value  = m_axis_tdata_o[31:0];
        got.entry_count = m_axis_tdata_o[36:32];
        if (pending_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            mismatches++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            mismatches++;
          end
        end
        recv_stall = pick_gap();
      end
      if (recv_stall > 0) begin
        m_axis_tready_i <= 1'b0;
        recv_stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ends the run if nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    mix_e        mix;
    int          r;
    int          ins_lim;
    int          rd_lim;
    int          er_lim;
    func_e       f;
    logic [3:0]  p;

    // empty set, extremes, duplicates, range errors, unused code
    queue_request(FUNC_READ,   32'h0,         4'd0);
    queue_request(FUNC_ERASE,  32'h0,         4'd15);
    queue_request(FUNC_NOP,    32'hffff_ffff, 4'd15);
    queue_request(FUNC_INSERT, 32'h0,         4'd0);
    queue_request(FUNC_INSERT, 32'h8000_0000, 4'd15);
    queue_request(FUNC_INSERT, 32'h7fff_ffff, 4'd7);
    queue_request(FUNC_INSERT, 32'h0,         4'd0);
    queue_request(FUNC_INSERT, 32'hffff_ffff, 4'd8);
    queue_request(FUNC_READ,   32'h0,         4'd0);
    queue_request(FUNC_READ,   32'h0,         4'd1);
    queue_request(FUNC_READ,   32'h0,         4'd3);
    queue_request(FUNC_READ,   32'h0,         4'd4);
    queue_request(FUNC_ERASE,  32'h0,         4'd3);
    queue_request(FUNC_ERASE,  32'h0,         4'd0);
    queue_request(FUNC_READ,   32'h0,         4'd0);
    queue_request(FUNC_NOP,    32'h0,         4'd0);
    queue_request(FUNC_INSERT, 32'h1,         4'd0);
    queue_request(FUNC_READ,   32'h0,         4'd15);
    queue_request(FUNC_ERASE,  32'h0,         4'd1);
    queue_request(FUNC_READ,   32'h0,         4'd2);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();

    for (int blk = 0; blk < 35; blk++) begin
      // hold the sender once until every result is back
      if (blk == 17) wait_drained();
      mix = mix_e'($urandom_range(2));
      case (mix)
        MIX_FILL:  begin ins_lim = 75; rd_lim = 85; er_lim = 95; end
        MIX_DRAIN: begin ins_lim = 20; rd_lim = 40; er_lim = 95; end
        default:   begin ins_lim = 40; rd_lim = 65; er_lim = 92; end
      endcase
      for (int k = 0; k < 50; k++) begin
        r = $urandom_range(99);
        if (r < ins_lim)     f = FUNC_INSERT;
        else if (r < rd_lim) f = FUNC_READ;
        else if (r < er_lim) f = FUNC_ERASE;
        else                 f = FUNC_NOP;
        // low positions drain the set faster
        if (mix == MIX_DRAIN && $urandom_range(1) == 1) p = 4'($urandom_range(3));
        else p = 4'($urandom_range(15));
        queue_request(f, random_value(), p);
      end
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sus_pkg.sv
rtl/sorted_unique_set_top.sv
tb/sv/sorted_unique_set_top_test.sv
